FILE: rtl/sipf_pkg.sv
// ----------------------------------------------------------------------------
// sipf_pkg
// Shared operation codes, header constants and the command record passed
// from the classifier to the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package sipf_pkg;

    localparam logic [1:0] OP_SINGLE  = 2'd0;
    localparam logic [1:0] OP_SYNC    = 2'd1;
    localparam logic [1:0] OP_PAYLOAD = 2'd2;

    localparam logic [7:0] HDR_BYTE        = 8'hff;
    localparam logic [7:0] SYNC_TARGET     = 8'hfe;
    localparam logic [7:0] LEN_NO_PARAM    = 8'd2;
    localparam logic [7:0] LEN_SINGLE_BASE = 8'd3;
    localparam logic [7:0] LEN_SYNC_BASE   = 8'd4;

    localparam int MAX_BYTES     = 8;
    localparam int BYTE_IDX_W    = $clog2(MAX_BYTES);
    localparam int REMAIN_W      = 16;
    localparam int QUEUE_DEPTH_D = 2;

    // One item's worth of output bytes, emitted from index 0 to last_idx.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [BYTE_IDX_W-1:0]     last_idx;
        logic                      err;
    } frame_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sipf_front.sv
// ----------------------------------------------------------------------------
// sipf_front
// Accepts items, tracks packet state and turns each item into a command
// holding every byte it produces, including header length and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module sipf_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [1:0]        operation,
    input  wire logic [7:0]        servo_id,
    input  wire logic [7:0]        instruction,
    input  wire logic [7:0]        address,
    input  wire logic [7:0]        param_count,
    input  wire logic [7:0]        servo_count,
    input  wire logic [7:0]        payload,
    input  wire logic              queue_full,
    output logic                   in_ready,
    output logic                   push,
    output sipf_pkg::frame_cmd_t   push_cmd
);
    import sipf_pkg::*;

    logic [7:0]          sum_reg, sum_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic                open_reg, open_next;

    logic [8:0]          plen_p1;
    logic [16:0]         body_prod;
    logic [REMAIN_W-1:0] body;
    logic [7:0]          single_len;
    logic [7:0]          sync_len;
    logic [7:0]          hdr_sum;
    logic [7:0]          pay_sum;
    logic [REMAIN_W-1:0] remain_dec;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign plen_p1    = {1'b0, param_count} + 9'd1;
    assign body_prod  = 17'(plen_p1) * 17'(servo_count);
    assign body       = body_prod[REMAIN_W-1:0];
    assign single_len = (param_count != 8'd0) ? (param_count + LEN_SINGLE_BASE) : LEN_NO_PARAM;
    assign sync_len   = body[7:0] + LEN_SYNC_BASE;
    assign pay_sum    = sum_reg + payload;
    assign remain_dec = remain_reg - REMAIN_W'(1);

    always_comb begin
        if (operation == OP_SINGLE) begin
            hdr_sum = servo_id + single_len + instruction
                    + ((param_count != 8'd0) ? address : 8'd0);
        end else begin
            hdr_sum = SYNC_TARGET + sync_len + instruction + address + param_count;
        end
    end

    always_comb begin
        sum_next    = sum_reg;
        remain_next = remain_reg;
        open_next   = open_reg;
        push_cmd    = '0;
        unique case (operation) inside
            OP_PAYLOAD: begin
                if (!open_reg || remain_reg == '0) begin
                    push_cmd.err      = 1'b1;
                    push_cmd.last_idx = '0;
                end else begin
                    push_cmd.bytes[0] = payload;
                    remain_next       = remain_dec;
                    if (remain_dec == '0) begin
                        // Close the packet with the checksum.
                        push_cmd.bytes[1] = ~pay_sum;
                        push_cmd.last_idx = BYTE_IDX_W'(1);
                        open_next         = 1'b0;
                        sum_next          = 8'd0;
                    end else begin
                        push_cmd.last_idx = '0;
                        sum_next          = pay_sum;
                    end
                end
            end
            OP_SINGLE, OP_SYNC: begin
                if (open_reg) begin
                    push_cmd.err      = 1'b1;
                    push_cmd.last_idx = '0;
                end else begin
                    push_cmd.bytes[0] = HDR_BYTE;
                    push_cmd.bytes[1] = HDR_BYTE;
                    if (operation == OP_SINGLE) begin
                        push_cmd.bytes[2] = servo_id;
                        push_cmd.bytes[3] = single_len;
                        push_cmd.bytes[4] = instruction;
                        push_cmd.last_idx = BYTE_IDX_W'(5);
                        remain_next       = REMAIN_W'(param_count);
                        if (param_count != 8'd0) begin
                            push_cmd.bytes[5] = address;
                            open_next         = 1'b1;
                            sum_next          = hdr_sum;
                        end else begin
                            push_cmd.bytes[5] = ~hdr_sum;
                            sum_next          = 8'd0;
                        end
                    end else begin
                        push_cmd.bytes[2] = SYNC_TARGET;
                        push_cmd.bytes[3] = sync_len;
                        push_cmd.bytes[4] = instruction;
                        push_cmd.bytes[5] = address;
                        push_cmd.bytes[6] = param_count;
                        remain_next       = body;
                        if (body != '0) begin
                            push_cmd.last_idx = BYTE_IDX_W'(6);
                            open_next         = 1'b1;
                            sum_next          = hdr_sum;
                        end else begin
                            push_cmd.bytes[7] = ~hdr_sum;
                            push_cmd.last_idx = BYTE_IDX_W'(7);
                            sum_next          = 8'd0;
                        end
                    end
                end
            end
            default: begin
                push_cmd.err      = 1'b1;
                push_cmd.last_idx = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= 8'd0;
            remain_reg <= '0;
            open_reg   <= 1'b0;
        end else if (push) begin
            sum_reg    <= sum_next;
            remain_reg <= remain_next;
            open_reg   <= open_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sipf_queue.sv
// ----------------------------------------------------------------------------
// sipf_queue
// Small first-in first-out queue of commands between classifier and
// serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module sipf_queue #(
    parameter int DEPTH = sipf_pkg::QUEUE_DEPTH_D
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire sipf_pkg::frame_cmd_t push_cmd,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output sipf_pkg::frame_cmd_t      head_cmd
);
    import sipf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_cmd_t           slots_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sipf_back.sv
// ----------------------------------------------------------------------------
// sipf_back
// Walks the head command one byte per cycle, unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sipf_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 head_valid,
    input  wire sipf_pkg::frame_cmd_t head_cmd,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                tx_byte,
    output logic                      last_byte,
    output logic                      error
);
    import sipf_pkg::*;

    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic                  err_reg;
    logic                  load;
    logic                  at_last;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head_cmd.last_idx);
    assign pop     = load && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_last ? '0 : idx_reg + BYTE_IDX_W'(1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head_cmd.err ? 8'd0 : head_cmd.bytes[idx_reg];
            last_reg <= at_last;
            err_reg  <= head_cmd.err;
        end
    end

    assign out_valid = valid_reg;
    assign tx_byte   = byte_reg;
    assign last_byte = last_reg;
    assign error     = err_reg;

endmodule

`default_nettype wire

FILE: rtl/servo_instruction_packet_framer.sv
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer
// Frames servo instruction packets (header, payload pass-through, inverted
// checksum) as a byte stream.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                              tuser          tlast
//  s_       in         id,instr,addr,pcount,scount,data  operation      -
//  m_       out        tx_byte                            error          last_byte
//
//  The front end accepts one item per cycle while the command queue has room.
//  The serializer emits one byte per cycle while m_ is not stalled: a start
//  item gives 6 to 8 bytes, a payload item 1 or 2 (2 when it closes the
//  packet), an error 1. Sustained rate is set by that byte serializer;
//  the queue absorbs bursts. Reset clears packet state, queue and output
//  stage. A stall on m_ backs up through the queue to s_tready only.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_instruction_packet_framer #(
    parameter int QUEUE_DEPTH = sipf_pkg::QUEUE_DEPTH_D
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // servo_id, instruction, address,
                                        // param_count, servo_count, payload
    input  wire logic [1:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // tx_byte
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // error
);
    import sipf_pkg::*;

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       head_valid;
    frame_cmd_t push_cmd;
    frame_cmd_t head_cmd;
    logic       err_bit;

    sipf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .operation   (s_tuser),
        .servo_id    (s_tdata[7:0]),
        .instruction (s_tdata[15:8]),
        .address     (s_tdata[23:16]),
        .param_count (s_tdata[31:24]),
        .servo_count (s_tdata[39:32]),
        .payload     (s_tdata[47:40]),
        .queue_full  (queue_full),
        .in_ready    (s_tready),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    sipf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sipf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .tx_byte    (m_tdata),
        .last_byte  (m_tlast),
        .error      (err_bit)
    );

    assign m_tuser = err_bit;

endmodule

`default_nettype wire

FILE: rtl/sipf_checker.sv
// ----------------------------------------------------------------------------
// sipf_checker
// Port-level checks on the framer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sipf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic [0:0]  m_tuser
);

    // An error result is a lone zero byte that ends its item.
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == 8'd0))
        else $error("error result not a single zero byte");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // Reset empties the output stage and the queue.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind servo_instruction_packet_framer sipf_checker u_sipf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
